/* design/assert_macros.svh */
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/schl_pkg.sv */
// types, codes and helper functions of the channel hop lookup
package schl_pkg;

    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_TIME_BITS    = 32;

    localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [1:0] REG_START_INDEX  = 2'd1;
    localparam logic [1:0] REG_START_TIME   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_EARLY       = 2'd2;

    localparam logic [2:0] LAST_SEG = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CLEAR,
        S_FIXED,
        S_SEG,
        S_PAIR_A,
        S_PAIR_B
    } seq_state_t;

    typedef struct packed {
        logic [8:0] a;
        logic [8:0] b;
        logic [7:0] cnt;
    } seg_t;

    // one restoring step of a remainder modulo len
    function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic bit_in,
                                           input logic [7:0] len);
        logic [8:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, len})
            return 8'(t - {1'b0, len});
        else
            return t[7:0];
    endfunction

    // table for four channels
    function automatic logic [6:0] fixed_entry(input logic [3:0] idx);
        logic [6:0] v;
        case (idx)
            4'd1:    v = 7'd1;
            4'd2:    v = 7'd1;
            4'd3:    v = 7'd4;
            4'd4:    v = 7'd2;
            4'd5:    v = 7'd3;
            4'd6:    v = 7'd2;
            4'd7:    v = 7'd4;
            4'd8:    v = 7'd3;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // pair run of the sequence construction: first pair (a,b), then a+1, b-1
    function automatic seg_t seg_params(input logic [6:0] n, input logic [2:0] seg);
        int m;
        int a;
        int b;
        int c;
        seg_t s;
        m = int'(n >> 2);
        a = 0;
        b = 0;
        c = 0;
        if (!n[0]) begin
            case (seg)
                3'd0:    begin a = 4 * m;     b = 8 * m;     c = 2 * m; end
                3'd1:    begin a = 2 * m + 1; b = 6 * m;     c = 1; end
                3'd2:    begin a = 2 * m;     b = 4 * m - 1; c = 1; end
                3'd3:    begin a = 1;         b = 4 * m - 2; c = (m >= 1) ? m - 1 : 0; end
                3'd4:    begin a = m;         b = m + 1;     c = 1; end
                3'd5:    begin a = m + 2;     b = 3 * m - 1; c = (m >= 2) ? m - 2 : 0; end
                default: c = 0;
            endcase
        end
        else begin
            case (seg)
                3'd0:    begin a = 4 * m + 2; b = 8 * m + 2; c = 2 * m; end
                3'd1:    begin a = 2 * m + 1; b = 6 * m + 2; c = 1; end
                3'd2:    begin a = 2 * m + 2; b = 4 * m + 1; c = 1; end
                3'd3:    begin a = 1;         b = 4 * m;     c = m; end
                3'd4:    begin a = m + 1;     b = m + 2;     c = 1; end
                3'd5:    begin a = m + 3;     b = 3 * m;     c = (m >= 2) ? m - 2 : 0; end
                default: c = 0;
            endcase
        end
        s.a   = 9'(a);
        s.b   = 9'(b);
        s.cnt = 8'(c);
        return s;
    endfunction

endpackage

/* design/schl_ram.sv */
// generic single write port ram with registered read
module schl_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 129
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/skolem_channel_hop_lookup.sv */
// skolem sequence channel hop lookup: table builder and pipelined slot lookup
//
//  channel   direction  handshake            fields
//  query     in         start & !busy        time_slot
//  result    out        done (one cycle)     channel, status
//  config    in         cfg_we               cfg_index, cfg_wdata
//
// one query per cycle while busy is low; done follows the accepting edge through the
// one-bit-per-stage division of the elapsed time by 2N and the slot, read and output registers
// writing num_channels starts a rebuild: start index reduction, clearing of all
// 2*MAX_CHANNELS+1 table entries, then for a supported N the fill (a segment step per
// segment and two writes per pair, or the fixed table for four channels)
// writing start_index alone runs only the reduction; busy is high during all of these
// after reset the table reads as unsupported and no clearing is needed
// results cannot be held off, so the pipeline never stalls
`include "assert_macros.svh"

module skolem_channel_hop_lookup
    import schl_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int TIME_BITS    = DEF_TIME_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] time_slot,
    output logic        done,
    output logic [6:0]  channel,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int DEPTH = 2 * MAX_CHANNELS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int TB    = TIME_BITS;

    // configuration
    logic [6:0]  num_reg;
    logic [7:0]  si_reg;
    logic [31:0] stime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= '0;
            si_reg    <= 8'd1;
            stime_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_CHANNELS: num_reg   <= cfg_wdata[6:0];
                REG_START_INDEX:  si_reg    <= cfg_wdata[7:0];
                REG_START_TIME:   stime_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    logic [7:0] len;
    logic       supported;
    assign len       = {num_reg, 1'b0};
    assign supported = (num_reg != 7'd0) && (int'(num_reg) <= MAX_CHANNELS) && !num_reg[1];

    // table builder
    seq_state_t state_reg, state_next;
    logic       rebuild_reg, rebuild_next;
    logic       ready_reg, ready_next;
    logic [2:0] mcnt_reg, mcnt_next;
    logic [7:0] mrem_reg, mrem_next;
    logic [7:0] si_mod_reg, si_mod_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [2:0] seg_reg, seg_next;
    logic [8:0] a_reg, a_next;
    logic [8:0] b_reg, b_next;
    logic [7:0] cnt_reg, cnt_next;
    seg_t       seg_cur;
    logic [7:0] mrem_step;

    assign seg_cur   = seg_params(num_reg, seg_reg);
    assign mrem_step = mod_step(mrem_reg, si_reg[3'd7 - mcnt_reg], len);

    always_comb
    begin
        state_next   = state_reg;
        rebuild_next = rebuild_reg;
        ready_next   = ready_reg;
        mcnt_next    = mcnt_reg;
        mrem_next    = mrem_reg;
        si_mod_next  = si_mod_reg;
        idx_next     = idx_reg;
        seg_next     = seg_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we && (cfg_index == REG_NUM_CHANNELS || cfg_index == REG_START_INDEX))
                begin
                    state_next   = S_MOD;
                    rebuild_next = (cfg_index == REG_NUM_CHANNELS);
                    mcnt_next    = '0;
                    mrem_next    = '0;
                    if (cfg_index == REG_NUM_CHANNELS)
                    begin
                        ready_next = 1'b0;
                    end
                end
            end
            S_MOD:
            begin
                mrem_next = mrem_step;
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd7)
                begin
                    si_mod_next = mrem_step;
                    idx_next    = '0;
                    state_next  = rebuild_reg ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AW'(DEPTH - 1))
                begin
                    idx_next     = '0;
                    seg_next     = '0;
                    rebuild_next = 1'b0;
                    if (!supported)
                        state_next = S_IDLE;
                    else if (num_reg == 7'd4)
                        state_next = S_FIXED;
                    else
                        state_next = S_SEG;
                end
            end
            S_FIXED:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AW'(8))
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            S_SEG:
            begin
                a_next   = seg_cur.a;
                b_next   = seg_cur.b;
                cnt_next = seg_cur.cnt;
                if (seg_cur.cnt != 8'd0)
                    state_next = S_PAIR_A;
                else if (seg_reg == LAST_SEG)
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
                else
                    seg_next = seg_reg + 3'd1;
            end
            S_PAIR_A:
            begin
                state_next = S_PAIR_B;
            end
            S_PAIR_B:
            begin
                a_next   = a_reg + 9'd1;
                b_next   = b_reg - 9'd1;
                cnt_next = cnt_reg - 8'd1;
                if (cnt_reg != 8'd1)
                    state_next = S_PAIR_A;
                else if (seg_reg == LAST_SEG)
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
                else
                begin
                    seg_next   = seg_reg + 3'd1;
                    state_next = S_SEG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [6:0]    wr_data;
    logic [8:0]    pos;

    assign pos = (state_reg == S_PAIR_B) ? b_reg : a_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_FIXED:
            begin
                wr_en   = 1'b1;
                wr_data = fixed_entry(idx_reg[3:0]);
            end
            S_PAIR_A, S_PAIR_B:
            begin
                // positions outside the sequence are dropped
                wr_en   = ({1'b0, len} >= pos) && (int'(pos) < DEPTH);
                wr_addr = AW'(pos);
                wr_data = 7'(b_reg - a_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rebuild_reg <= 1'b0;
            ready_reg   <= 1'b0;
            mcnt_reg    <= '0;
            idx_reg     <= '0;
            seg_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rebuild_reg <= rebuild_next;
            ready_reg   <= ready_next;
            mcnt_reg    <= mcnt_next;
            idx_reg     <= idx_next;
            seg_reg     <= seg_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mrem_reg   <= mrem_next;
        si_mod_reg <= si_mod_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
    end

    assign busy = (state_reg != S_IDLE);

    // lookup pipeline
    logic          accept;
    logic [63:0]   t_ext;
    logic [63:0]   st_ext;
    logic [TB-1:0] t_cut;
    logic [TB-1:0] st_cut;
    logic [1:0]    status_in;

    assign accept = start && !busy;
    assign t_ext  = {32'd0, time_slot};
    assign st_ext = {32'd0, stime_reg};
    assign t_cut  = t_ext[TB-1:0];
    assign st_cut = st_ext[TB-1:0];

    always_comb
    begin
        if (!ready_reg)
            status_in = ST_UNSUPPORTED;
        else if (t_cut < st_cut)
            status_in = ST_EARLY;
        else
            status_in = ST_OK;
    end

    logic          pv_reg  [TB+1];
    logic [1:0]    ps_reg  [TB+1];
    logic [TB-1:0] pd_reg  [TB+1];
    logic [7:0]    pr1_reg [TB+1];
    logic [7:0]    pr2_reg [TB+1];
    logic          qb      [TB];
    logic [7:0]    r1n     [TB];
    logic [7:0]    r2n     [TB];

    // remainder of d and of its quotient, both modulo 2N, one bit per stage
    always_comb
    begin
        for (int k = 0; k < TB; k++)
        begin
            qb[k]  = ({pr1_reg[k], pd_reg[k][TB-1]} >= {1'b0, len});
            r1n[k] = mod_step(pr1_reg[k], pd_reg[k][TB-1], len);
            r2n[k] = mod_step(pr2_reg[k], qb[k], len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= TB; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            pv_reg[0] <= accept;
            for (int k = 0; k < TB; k++)
            begin
                pv_reg[k+1] <= pv_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg[0]  <= status_in;
        pd_reg[0]  <= t_cut - st_cut;
        pr1_reg[0] <= '0;
        pr2_reg[0] <= '0;
        for (int k = 0; k < TB; k++)
        begin
            ps_reg[k+1]  <= ps_reg[k];
            pd_reg[k+1]  <= pd_reg[k] << 1;
            pr1_reg[k+1] <= r1n[k];
            pr2_reg[k+1] <= r2n[k];
        end
    end

    // slot reduction, table read, output
    logic [9:0] sum_a;
    logic [9:0] len2;
    logic [8:0] sa_reg;
    logic       va_reg;
    logic [1:0] sta_reg;
    logic [8:0] sb;
    logic [AW-1:0] slot;
    logic       vb_reg;
    logic [1:0] stb_reg;
    logic [6:0] rdata;
    logic       done_reg;
    logic [1:0] status_reg;
    logic [6:0] channel_reg;

    assign len2  = {1'b0, len, 1'b0};
    assign sum_a = {2'b0, si_mod_reg} + {2'b0, pr1_reg[TB]} + {2'b0, pr2_reg[TB]}
                 + {2'b0, len} - 10'd1;
    assign sb    = (sa_reg >= {1'b0, len}) ? (sa_reg - {1'b0, len}) : sa_reg;
    assign slot  = AW'(sb + 9'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= pv_reg[TB];
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg      <= (sum_a >= len2) ? 9'(sum_a - len2) : sum_a[8:0];
        sta_reg     <= ps_reg[TB];
        stb_reg     <= sta_reg;
        status_reg  <= stb_reg;
        channel_reg <= (stb_reg == ST_OK) ? rdata : 7'd0;
    end

    schl_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (slot),
        .rdata (rdata)
    );

    assign done    = done_reg;
    assign status  = status_reg;
    assign channel = channel_reg;

    `ASSERT_IMPLIES(a_fixed_latency, clk, rst_n, accept, ##(TB + 4) done)
    `ASSERT_IMPLIES(a_flag_zero_channel, clk, rst_n, done && status != ST_OK, channel == 7'd0)
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, done, status != 2'd3)
    `ASSERT_IMPLIES(a_no_item_in_rebuild, clk, rst_n, wr_en, !pv_reg[0])

endmodule
